[sv/buddy_block_allocator_top_macros.svh]
// Assertion macros used by the allocator walker module.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BBA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

`define BBA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: check failed");

`else

`define BBA_ASSERT_IMP(lbl, ante, cons)

`define BBA_ASSERT_ALWAYS(lbl, expr)

`endif

`endif

[sv/bba_pkg.sv]
package bba_pkg;

    localparam int POOL_BLOCKS_DEF = 1024;

    localparam int REQ_W  = 11;
    localparam int OFF_W  = 10;
    localparam int CNT_W  = 11;
    localparam int ST_W   = 2;
    localparam int ADDR_W = 11;
    localparam int NODE_W = 4;
    localparam int ORD_W  = NODE_W;

    localparam logic [NODE_W-1:0] NODE_USED = '1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_REQ   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [REQ_W-1:0] req_blocks;
        logic [OFF_W-1:0] free_offset;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [OFF_W-1:0] block_offset;
        logic [CNT_W-1:0] used_blocks;
    } rsp_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [NODE_W-1:0] wdata;
    } mem_cmd_t;

    function automatic logic [ORD_W-1:0] ceil_log2_req(input logic [REQ_W-1:0] x);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < REQ_W; i++)
        begin
            if (x > (REQ_W'(1) << i))
            begin
                r = ORD_W'(i + 1);
            end
        end
        return r;
    endfunction

    function automatic logic [ORD_W-1:0] floor_log2_addr(input logic [ADDR_W-1:0] x);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (x[i])
            begin
                r = ORD_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] node_parent(input logic [ADDR_W-1:0] x);
        logic [ADDR_W-1:0] t;
        t = x - ADDR_W'(1);
        return t >> 1;
    endfunction

    function automatic logic [ADDR_W-1:0] node_sibling(input logic [ADDR_W-1:0] x);
        return x[0] ? x + ADDR_W'(1) : x - ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] node_left(input logic [ADDR_W-1:0] x);
        return {x[ADDR_W-2:0], 1'b1};
    endfunction

endpackage

[sv/bba_ifs.sv]
interface bba_cmd_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [REQ_W-1:0] req_blocks;
    logic [OFF_W-1:0] free_offset;

    modport source (output valid, output cmd, output req_blocks, output free_offset,
                    input ready);
    modport sink   (input valid, input cmd, input req_blocks, input free_offset,
                    output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] used_blocks;

    modport source (output valid, output status, output block_offset, output used_blocks,
                    input ready);
    modport sink   (input valid, input status, input block_offset, input used_blocks,
                    output ready);
endinterface

[sv/bba_tree_mem.sv]
module bba_tree_mem import bba_pkg::*; #(
    parameter int DEPTH = 2 * POOL_BLOCKS_DEF - 1
) (
    input  logic              clk,
    input  mem_cmd_t          mem_cmd,
    output logic [NODE_W-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [NODE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_cmd.we)
        begin
            mem[mem_cmd.waddr[AW-1:0]] <= mem_cmd.wdata;
        end
        if (mem_cmd.re)
        begin
            rdata <= mem[mem_cmd.raddr[AW-1:0]];
        end
    end

endmodule

[sv/bba_walker.sv]
`include "buddy_block_allocator_top_macros.svh"

module bba_walker import bba_pkg::*; #(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    output mem_cmd_t          mem_cmd,
    input  logic [NODE_W-1:0] mem_rdata
);

    localparam int TOP   = $clog2(POOL_BLOCKS);
    localparam int NODES = 2 * POOL_BLOCKS - 1;

    localparam logic [ORD_W-1:0]  TOP_ORD   = ORD_W'(TOP);
    localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);
    localparam logic [ADDR_W-1:0] POOL_ADDR = ADDR_W'(POOL_BLOCKS);
    localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_BLOCKS);

    localparam int S_W = 3;
    localparam logic [S_W-1:0] S_INIT  = 3'd0;
    localparam logic [S_W-1:0] S_IDLE  = 3'd1;
    localparam logic [S_W-1:0] S_ROOT  = 3'd2;
    localparam logic [S_W-1:0] S_DOWN  = 3'd3;
    localparam logic [S_W-1:0] S_UP    = 3'd4;
    localparam logic [S_W-1:0] S_CLIMB = 3'd5;
    localparam logic [S_W-1:0] S_DONE  = 3'd6;

    logic [S_W-1:0]    state_reg,    state_next;
    logic [ADDR_W-1:0] init_reg,     init_next;
    logic [CNT_W-1:0]  used_reg,     used_next;
    logic              free_reg,     free_next;
    logic [ORD_W-1:0]  k_reg,        k_next;
    logic [ORD_W-1:0]  ord_reg,      ord_next;
    logic [ADDR_W-1:0] idx_reg,      idx_next;
    logic [OFF_W-1:0]  off_reg,      off_next;
    logic [NODE_W-1:0] val_reg,      val_next;
    logic [ST_W-1:0]   status_reg,   status_next;
    logic [OFF_W-1:0]  res_off_reg,  res_off_next;

    logic [ORD_W-1:0]  req_ord;
    logic [CNT_W:0]    alloc_sum;
    logic [CNT_W-1:0]  used_alloc;
    logic [CNT_W-1:0]  run_blocks;
    logic [CNT_W-1:0]  used_free;
    logic [ADDR_W-1:0] left_idx;
    logic              left_fits;
    logic [ADDR_W-1:0] down_idx;
    logic [ORD_W-1:0]  down_ord;
    logic [OFF_W-1:0]  down_off;
    logic [ADDR_W-1:0] par_idx;
    logic [NODE_W-1:0] l_val;
    logic [NODE_W-1:0] r_val;
    logic [NODE_W-1:0] par_val;

    assign req_ord    = ceil_log2_req(cmd.req_blocks);
    assign alloc_sum  = {1'b0, used_reg} + ((CNT_W + 1)'(1) << k_reg);
    assign used_alloc = (alloc_sum > (CNT_W + 1)'(POOL_BLOCKS)) ? POOL_CNT
                                                                : alloc_sum[CNT_W-1:0];
    assign run_blocks = CNT_W'(1) << ord_reg;
    assign used_free  = (used_reg >= run_blocks) ? used_reg - run_blocks : '0;

    assign left_idx  = node_left(idx_reg);
    assign left_fits = (mem_rdata != NODE_USED) && (mem_rdata >= k_reg);
    assign down_idx  = left_fits ? left_idx : left_idx + ADDR_W'(1);
    assign down_ord  = ord_reg - ORD_W'(1);
    assign down_off  = left_fits ? off_reg : off_reg | (OFF_W'(1) << down_ord);

    assign par_idx = node_parent(idx_reg);
    assign l_val   = idx_reg[0] ? val_reg : mem_rdata;
    assign r_val   = idx_reg[0] ? mem_rdata : val_reg;

    always_comb
    begin
        if (free_reg && (l_val == ord_reg) && (r_val == ord_reg))
        begin
            par_val = ord_reg + ORD_W'(1);
        end
        else if (l_val == NODE_USED)
        begin
            par_val = r_val;
        end
        else if (r_val == NODE_USED)
        begin
            par_val = l_val;
        end
        else
        begin
            par_val = (l_val > r_val) ? l_val : r_val;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        init_next    = init_reg;
        used_next    = used_reg;
        free_next    = free_reg;
        k_next       = k_reg;
        ord_next     = ord_reg;
        idx_next     = idx_reg;
        off_next     = off_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        res_off_next = res_off_reg;
        mem_cmd      = '0;
        cmd_ready    = 1'b0;
        rsp_valid    = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = init_reg;
                mem_cmd.wdata = TOP_ORD - floor_log2_addr(init_reg + ADDR_W'(1));
                init_next     = init_reg + ADDR_W'(1);
                if (init_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    free_next    = (cmd.cmd == CMD_FREE);
                    status_next  = ST_OK;
                    res_off_next = '0;
                    k_next       = req_ord;
                    ord_next     = '0;
                    if (cmd.cmd == CMD_ALLOC)
                    begin
                        if ((cmd.req_blocks == '0) || (cmd.req_blocks > REQ_W'(POOL_BLOCKS)))
                        begin
                            status_next = ST_BAD_REQ;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            mem_cmd.re    = 1'b1;
                            mem_cmd.raddr = '0;
                            state_next    = S_ROOT;
                        end
                    end
                    else if (ADDR_W'(cmd.free_offset) >= POOL_ADDR)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next      = ADDR_W'(cmd.free_offset) + (POOL_ADDR - ADDR_W'(1));
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = idx_next;
                        state_next    = S_CLIMB;
                    end
                end
            end

            S_ROOT:
            begin
                idx_next = '0;
                ord_next = TOP_ORD;
                off_next = '0;
                if ((mem_rdata == NODE_USED) || (mem_rdata < k_reg))
                begin
                    status_next = ST_BAD_REQ;
                    state_next  = S_DONE;
                end
                else if (TOP_ORD == k_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = '0;
                    mem_cmd.wdata = NODE_USED;
                    used_next     = used_alloc;
                    state_next    = S_DONE;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = ADDR_W'(1);
                    state_next    = S_DOWN;
                end
            end

            S_DOWN:
            begin
                idx_next = down_idx;
                ord_next = down_ord;
                off_next = down_off;
                if (down_ord == k_reg)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = down_idx;
                    mem_cmd.wdata = NODE_USED;
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = node_sibling(down_idx);
                    val_next      = NODE_USED;
                    used_next     = used_alloc;
                    res_off_next  = down_off;
                    state_next    = S_UP;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = node_left(down_idx);
                end
            end

            S_UP:
            begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = par_idx;
                mem_cmd.wdata = par_val;
                val_next      = par_val;
                idx_next      = par_idx;
                ord_next      = ord_reg + ORD_W'(1);
                if (par_idx == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = node_sibling(par_idx);
                end
            end

            S_CLIMB:
            begin
                if (mem_rdata == NODE_USED)
                begin
                    mem_cmd.we    = 1'b1;
                    mem_cmd.waddr = idx_reg;
                    mem_cmd.wdata = ord_reg;
                    val_next      = ord_reg;
                    used_next     = used_free;
                    if (idx_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_cmd.re    = 1'b1;
                        mem_cmd.raddr = node_sibling(idx_reg);
                        state_next    = S_UP;
                    end
                end
                else if (idx_reg == '0)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next      = par_idx;
                    ord_next      = ord_reg + ORD_W'(1);
                    mem_cmd.re    = 1'b1;
                    mem_cmd.raddr = par_idx;
                end
            end

            S_DONE:
            begin
                rsp_valid = 1'b1;
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg    <= free_next;
        k_reg       <= k_next;
        ord_reg     <= ord_next;
        idx_reg     <= idx_next;
        off_reg     <= off_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        res_off_reg <= res_off_next;
    end

    assign rsp.status       = status_reg;
    assign rsp.block_offset = res_off_reg;
    assign rsp.used_blocks  = used_reg;

    `BBA_ASSERT_ALWAYS(a_used_bound, used_reg <= POOL_CNT)
    `BBA_ASSERT_IMP(a_no_rw_clash, mem_cmd.we && mem_cmd.re, mem_cmd.waddr != mem_cmd.raddr)
    `BBA_ASSERT_IMP(a_idle_no_write, cmd_ready, !mem_cmd.we)
    `BBA_ASSERT_IMP(a_read_before_use, (state_reg == S_ROOT) || (state_reg == S_DOWN) || (state_reg == S_UP) || (state_reg == S_CLIMB), $past(mem_cmd.re))

endmodule

[sv/buddy_block_allocator_top.sv]
// Channel   Dir  Fields                                   Transfer
// cmd_bus   in   cmd, req_blocks, free_offset             valid && ready
// rsp_bus   out  status, block_offset, used_blocks        valid && ready
//
// After reset every node of the tree (2*POOL_BLOCKS-1 nodes) is written once, with cmd_bus.ready low.
// One command at a time: each tree level takes one read on the single read port.
// Alloc of 2^k blocks walks down from the root to a free node of order k, then updates the nodes above it.
// Free climbs to the used node and back up; an offset past the pool gets ST_NOT_FOUND.
// A held result in the output register lets the next command start; a second
// result waits inside the walker until rsp_bus drains.
module buddy_block_allocator_top import bba_pkg::*; #(
    parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    bba_cmd_if.sink   cmd_bus,
    bba_rsp_if.source rsp_bus
);

    cmd_t              cmd_w;
    rsp_t              rsp_w;
    logic              rsp_valid_w;
    logic              rsp_ready_w;
    mem_cmd_t          mem_cmd_w;
    logic [NODE_W-1:0] mem_rdata_w;

    logic out_valid_reg, out_valid_next;
    rsp_t out_reg;

    assign cmd_w.cmd         = cmd_bus.cmd;
    assign cmd_w.req_blocks  = cmd_bus.req_blocks;
    assign cmd_w.free_offset = cmd_bus.free_offset;

    bba_walker #(
        .POOL_BLOCKS (POOL_BLOCKS)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_bus.valid),
        .cmd_ready (cmd_bus.ready),
        .cmd       (cmd_w),
        .rsp_valid (rsp_valid_w),
        .rsp_ready (rsp_ready_w),
        .rsp       (rsp_w),
        .mem_cmd   (mem_cmd_w),
        .mem_rdata (mem_rdata_w)
    );

    bba_tree_mem #(
        .DEPTH (2 * POOL_BLOCKS - 1)
    ) u_tree_mem (
        .clk     (clk),
        .mem_cmd (mem_cmd_w),
        .rdata   (mem_rdata_w)
    );

    assign rsp_ready_w = !out_valid_reg || rsp_bus.ready;

    always_comb
    begin
        if (rsp_valid_w && rsp_ready_w)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_bus.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_valid_w && rsp_ready_w)
        begin
            out_reg <= rsp_w;
        end
    end

    assign rsp_bus.valid        = out_valid_reg;
    assign rsp_bus.status       = out_reg.status;
    assign rsp_bus.block_offset = out_reg.block_offset;
    assign rsp_bus.used_blocks  = out_reg.used_blocks;

endmodule
